FILE: src/omt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omt_pkg: shared types for the owned mutex table
// Command and status codes, controller states and the control and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package omt_pkg;

	localparam int CMD_W  = 2;
	localparam int SLOT_W = 8;
	localparam int PID_W  = 16;
	localparam int STS_W  = 2;

	// request kinds
	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 2'd0,
		CMD_LOCK   = 2'd1,
		CMD_UNLOCK = 2'd2,
		CMD_FREE   = 2'd3
	} cmd_e_t;

	// response codes
	typedef enum logic [STS_W-1:0] {
		RSP_OK   = 2'd0,
		RSP_ERR  = 2'd1,
		RSP_BUSY = 2'd2
	} rsp_e_t;

	// controller states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_e_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic out_valid;
	} sts_t;

endpackage

FILE: src/omt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omt_req_if: request channel
// Valid/ready channel carrying one mutex request per beat.
// ----------------------------------------------------------------------------
interface omt_req_if;
	logic                               valid;
	logic                               ready;
	omt_pkg::cmd_e_t                    cmd;
	logic [omt_pkg::SLOT_W-1:0]         slot_id;
	logic [omt_pkg::PID_W-1:0]          caller_pid;

	modport source (output valid, output cmd, output slot_id, output caller_pid,
		input ready);
	modport sink (input valid, input cmd, input slot_id, input caller_pid,
		output ready);
endinterface

FILE: src/omt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omt_rsp_if: response channel
// Valid/ready channel carrying one mutex response per beat.
// ----------------------------------------------------------------------------
interface omt_rsp_if;
	logic                           valid;
	logic                           ready;
	omt_pkg::rsp_e_t                status;
	logic [omt_pkg::SLOT_W-1:0]     result_slot;
	logic                           wake;

	modport source (output valid, output status, output result_slot, output wake,
		input ready);
	modport sink (input valid, input status, input result_slot, input wake,
		output ready);
endinterface

FILE: src/omt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omt_ctrl: request sequencer
// Accepts a request when idle and the result register is free or draining,
// then executes it in the datapath in the EXEC state.
// ----------------------------------------------------------------------------
module omt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          out_ready,
	input  omt_pkg::sts_t sts,
	output logic          in_ready,
	output omt_pkg::ctl_t ctl
);

	omt_pkg::state_e_t state_q;
	omt_pkg::state_e_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= omt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			omt_pkg::ST_IDLE: begin
				if (ctl.load) state_d = omt_pkg::ST_EXEC;
			end
			omt_pkg::ST_EXEC: begin
				state_d = omt_pkg::ST_IDLE;
			end
			default: state_d = omt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		ctl      = '0;
		unique case (state_q)
			omt_pkg::ST_IDLE: begin
				in_ready = !sts.out_valid || out_ready;
				ctl.load = in_ready && in_valid;
			end
			omt_pkg::ST_EXEC: begin
				ctl.exec = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// every accepted beat is executed in the following cycle
	a_load_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> ctl.exec)
		else $error("accepted request not executed");

	// no new beat while a request is being executed
	a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |-> !in_ready)
		else $error("ready raised during execution");

	// an execute cycle is never directly followed by another
	a_single_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.exec |=> !ctl.exec)
		else $error("back to back execute cycles");

endmodule

FILE: src/omt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// omt_datapath: mutex table storage and request evaluation
// Owner id memory, per-slot locked and owner-zero flags, request and
// result registers, lowest-free-slot encoder.
// ----------------------------------------------------------------------------
module omt_datapath #(
	parameter int TABLE_SIZE = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  omt_pkg::ctl_t               ctl,
	output omt_pkg::sts_t               sts,
	input  omt_pkg::cmd_e_t             in_cmd,
	input  logic [omt_pkg::SLOT_W-1:0]  in_slot_id,
	input  logic [omt_pkg::PID_W-1:0]   in_caller_pid,
	input  logic                        out_ready,
	output logic                        out_valid,
	output omt_pkg::rsp_e_t             out_status,
	output logic [omt_pkg::SLOT_W-1:0]  out_result_slot,
	output logic                        out_wake
);

	localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

	// owner id memory, valid only where the owner-zero flag is clear
	logic [omt_pkg::PID_W-1:0] owner_mem [TABLE_SIZE];
	logic [omt_pkg::PID_W-1:0] owner_rd_q;

	logic [TABLE_SIZE-1:0]     locked_q;
	logic [TABLE_SIZE-1:0]     zero_q;

	omt_pkg::cmd_e_t           cmd_q;
	logic [omt_pkg::SLOT_W-1:0] slot_q;
	logic [omt_pkg::PID_W-1:0] pid_q;

	logic                      out_valid_q;
	omt_pkg::rsp_e_t           status_q;
	logic [omt_pkg::SLOT_W-1:0] rslot_q;
	logic                      wake_q;

	logic                      in_range;
	logic [IW-1:0]             idx;
	logic [omt_pkg::PID_W-1:0] owner_cur;
	logic                      free_found;
	logic [IW-1:0]             free_idx;

	logic                      mem_we;
	logic                      zero_we;
	logic                      zero_val;
	logic [IW-1:0]             upd_idx;
	logic                      lock_set;
	logic                      lock_clr;
	omt_pkg::rsp_e_t           status_d;
	logic [omt_pkg::SLOT_W-1:0] rslot_d;
	logic                      wake_d;

	// request capture, memory read addressed by the incoming slot
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q      <= in_cmd;
			slot_q     <= in_slot_id;
			pid_q      <= in_caller_pid;
			owner_rd_q <= owner_mem[in_slot_id[IW-1:0]];
		end
		if (mem_we) begin
			owner_mem[upd_idx] <= pid_q;
		end
	end

	assign in_range  = {1'b0, slot_q} < (omt_pkg::SLOT_W+1)'(TABLE_SIZE);
	assign idx       = slot_q[IW-1:0];
	assign owner_cur = zero_q[idx] ? '0 : owner_rd_q;

	// lowest slot whose owner is zero
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
			if (zero_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// request evaluation
	always_comb begin
		mem_we   = 1'b0;
		zero_we  = 1'b0;
		zero_val = 1'b0;
		upd_idx  = idx;
		lock_set = 1'b0;
		lock_clr = 1'b0;
		status_d = omt_pkg::RSP_ERR;
		rslot_d  = slot_q;
		wake_d   = 1'b0;
		if (ctl.exec) begin
			unique case (cmd_q)
				omt_pkg::CMD_CREATE: begin
					upd_idx = free_idx;
					if (free_found) begin
						mem_we   = 1'b1;
						zero_we  = 1'b1;
						zero_val = (pid_q == '0);
						status_d = omt_pkg::RSP_OK;
						rslot_d  = omt_pkg::SLOT_W'(free_idx);
					end else begin
						rslot_d  = '0;
					end
				end
				omt_pkg::CMD_LOCK: begin
					if (in_range) begin
						if (locked_q[idx]) begin
							status_d = omt_pkg::RSP_BUSY;
						end else begin
							mem_we   = 1'b1;
							zero_we  = 1'b1;
							zero_val = (pid_q == '0);
							lock_set = 1'b1;
							status_d = omt_pkg::RSP_OK;
						end
					end
				end
				omt_pkg::CMD_UNLOCK, omt_pkg::CMD_FREE: begin
					if (in_range && owner_cur == pid_q) begin
						zero_we  = 1'b1;
						zero_val = 1'b1;
						lock_clr = 1'b1;
						status_d = omt_pkg::RSP_OK;
						wake_d   = 1'b1;
					end
				end
				default: status_d = omt_pkg::RSP_ERR;
			endcase
		end
	end

	// slot flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= '0;
			zero_q   <= '1;
		end else begin
			if (zero_we)  zero_q[upd_idx]   <= zero_val;
			if (lock_set) locked_q[upd_idx] <= 1'b1;
			if (lock_clr) locked_q[upd_idx] <= 1'b0;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			status_q <= status_d;
			rslot_q  <= rslot_d;
			wake_q   <= wake_d;
		end
	end

	assign sts.out_valid   = out_valid_q;
	assign out_valid       = out_valid_q;
	assign out_status      = status_q;
	assign out_result_slot = rslot_q;
	assign out_wake        = wake_q;

	// a result only appears after an execute cycle
	a_rose_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctl.exec))
		else $error("result beat without execution");

	// wake only on a successful release
	a_wake_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && wake_q |-> status_q == omt_pkg::RSP_OK)
		else $error("wake on non-success result");

	// a successful release leaves the slot free and unlocked
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		lock_clr |=> zero_q[$past(upd_idx)] && !locked_q[$past(upd_idx)])
		else $error("released slot not cleared");

endmodule

FILE: src/owned_mutex_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owned_mutex_table: hardware mutex table with owner tracking
// Create, lock, unlock and free requests against TABLE_SIZE mutex slots.
// ----------------------------------------------------------------------------
// The accepting edge captures the request and reads the owner id memory at
// the addressed slot; in the execute state the request is evaluated, the slot
// updated and the result register loaded. A new request is accepted in the cycle
// the previous result is taken (or later), so back-pressure on the response
// channel holds off requests. Create returns the lowest slot whose owner is
// zero; lock answers busy on a locked slot and the caller retries after a
// wake; unlock and free clear the slot when the caller owns it and raise
// wake. Lock, unlock and free on slots outside the table answer error. All
// slots are free and unlocked out of reset, with no clearing pass.
module owned_mutex_table #(
	parameter int TABLE_SIZE = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	omt_req_if.sink    req,
	omt_rsp_if.source  rsp
);

	omt_pkg::ctl_t ctl;
	omt_pkg::sts_t sts;

	// sequencer
	omt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.in_ready  (req.ready),
		.ctl       (ctl)
	);

	// table and result path
	omt_datapath #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.in_cmd          (req.cmd),
		.in_slot_id      (req.slot_id),
		.in_caller_pid   (req.caller_pid),
		.out_ready       (rsp.ready),
		.out_valid       (rsp.valid),
		.out_status      (rsp.status),
		.out_result_slot (rsp.result_slot),
		.out_wake        (rsp.wake)
	);

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the owned mutex table
// Drives create, lock, unlock and free requests through the request channel.
// A scoreboard class keeps its own copy of the slot table, works out each
// response as requests are accepted, and checks every response beat in
// order. A directed opener hits the corner cases. Random traffic follows,
// mostly owner-aware sequences plus some noise. The sender works in bursts,
// and the receiver stalls and sometimes holds off for long stretches.
// ----------------------------------------------------------------------------
module testbench;

	localparam int NUM_SLOTS    = 16;
	localparam int RANDOM_ITEMS = 925;
	localparam int LIMIT_NS     = 1_000_000;

	typedef struct packed {
		omt_pkg::rsp_e_t              status;
		logic [omt_pkg::SLOT_W-1:0]   slot;
		logic                         wake;
	} mutex_rsp_t;

	// slot table copy, response prediction and in-order response checking
	class mutex_tracker;
		bit                          locked [NUM_SLOTS];
		logic [omt_pkg::PID_W-1:0]   owner  [NUM_SLOTS];
		mutex_rsp_t                  pending_rsp [$];
		int                          mismatches;
		int                          n_req, n_rsp, n_ok, n_err, n_busy, n_wake, n_full;

		function new();
			foreach (owner[i]) begin
				owner[i]  = '0;
				locked[i] = 1'b0;
			end
		endfunction

		// apply one request to the table and return its response
		function mutex_rsp_t apply_request(omt_pkg::cmd_e_t c,
			logic [omt_pkg::SLOT_W-1:0] s, logic [omt_pkg::PID_W-1:0] p);
			mutex_rsp_t r;
			bit         found;
			r.status = omt_pkg::RSP_ERR;
			r.slot   = s;
			r.wake   = 1'b0;
			found    = 1'b0;
			case (c)
				omt_pkg::CMD_CREATE: begin
					r.slot = '0;
					for (int i = 0; i < NUM_SLOTS; i++) begin
						if (!found && owner[i] == '0) begin
							owner[i] = p;
							r.status = omt_pkg::RSP_OK;
							r.slot   = i[omt_pkg::SLOT_W-1:0];
							found    = 1'b1;
						end
					end
				end
				omt_pkg::CMD_LOCK: begin
					if (s < NUM_SLOTS) begin
						if (locked[s]) begin
							r.status = omt_pkg::RSP_BUSY;
						end else begin
							locked[s] = 1'b1;
							owner[s]  = p;
							r.status  = omt_pkg::RSP_OK;
						end
					end
				end
				default: begin
					// unlock and free share one rule: caller must be the owner
					if (s < NUM_SLOTS && owner[s] == p) begin
						locked[s] = 1'b0;
						owner[s]  = '0;
						r.status  = omt_pkg::RSP_OK;
						r.wake    = 1'b1;
					end
				end
			endcase
			return r;
		endfunction

		function void note_request(omt_pkg::cmd_e_t c, logic [omt_pkg::SLOT_W-1:0] s,
			logic [omt_pkg::PID_W-1:0] p);
			mutex_rsp_t r;
			r = apply_request(c, s, p);
			if (c == omt_pkg::CMD_CREATE && r.status == omt_pkg::RSP_ERR)
				n_full++;
			n_req++;
			pending_rsp.push_back(r);
		endfunction

		function void check_response(omt_pkg::rsp_e_t st, logic [omt_pkg::SLOT_W-1:0] sl,
			logic wk);
			mutex_rsp_t e;
			n_rsp++;
			if (pending_rsp.size() == 0) begin
				mismatches++;
				$display("%0t: response beat with none pending: status %0d slot %0d wake %0d",
					$time, st, sl, wk);
				return;
			end
			e = pending_rsp.pop_front();
			if (st !== e.status) begin
				mismatches++;
				$display("%0t: status expected %0d actual %0d", $time, e.status, st);
			end
			if (sl !== e.slot) begin
				mismatches++;
				$display("%0t: result_slot expected %0d actual %0d", $time, e.slot, sl);
			end
			if (wk !== e.wake) begin
				mismatches++;
				$display("%0t: wake expected %0d actual %0d", $time, e.wake, wk);
			end
			case (e.status)
				omt_pkg::RSP_OK:   n_ok++;
				omt_pkg::RSP_BUSY: n_busy++;
				default:           n_err++;
			endcase
			if (e.wake)
				n_wake++;
		endfunction
	endclass

	logic clk;
	logic arst_n;

	omt_req_if req_ch ();
	omt_rsp_if rsp_ch ();

	owned_mutex_table #(
		.TABLE_SIZE(NUM_SLOTS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	mutex_tracker mirror    = new();
	mutex_tracker stim_view = new();
	int           burst_left = 0;

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	// run limit
	initial begin
		#(LIMIT_NS);
		$display("testbench NOT OK");
		$finish;
	end

	// monitor both channels at the clock edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				mirror.check_response(rsp_ch.status, rsp_ch.result_slot, rsp_ch.wake);
			if (req_ch.valid && req_ch.ready)
				mirror.note_request(req_ch.cmd, req_ch.slot_id, req_ch.caller_pid);
		end
	end

	// response side: stall patterns that change over time, plus long holds
	initial begin
		int cyc;
		int hold;
		int mode;
		cyc  = 0;
		hold = 0;
		mode = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 500 == 250)
				hold = $urandom_range(40, 90);
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			if (hold > 0) begin
				hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0:       rsp_ch.ready <= 1'b1;
					1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
					2:       rsp_ch.ready <= (cyc % 4 == 0);
					default: rsp_ch.ready <= (cyc % 2 == 0);
				endcase
			end
		end
	end

	// offer one request beat and wait for it to be taken, then maybe pause
	task automatic send_request(omt_pkg::cmd_e_t c, logic [omt_pkg::SLOT_W-1:0] s,
		logic [omt_pkg::PID_W-1:0] p);
		void'(stim_view.apply_request(c, s, p));
		req_ch.valid      <= 1'b1;
		req_ch.cmd        <= c;
		req_ch.slot_id    <= s;
		req_ch.caller_pid <= p;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(0, 12);
		end
	endtask

	// pick a random owned slot (or a locked one), -1 if none
	function automatic int find_slot(bit need_lock);
		int start;
		int idx;
		int hit;
		start = $urandom_range(0, NUM_SLOTS - 1);
		hit   = -1;
		for (int k = 0; k < NUM_SLOTS; k++) begin
			idx = (start + k) % NUM_SLOTS;
			if (hit < 0 && (need_lock ? stim_view.locked[idx] : stim_view.owner[idx] != '0))
				hit = idx;
		end
		return hit;
	endfunction

	// reset, directed opener, random traffic, drain
	initial begin
		int                        pick;
		int                        s;
		omt_pkg::cmd_e_t           c;
		logic [omt_pkg::PID_W-1:0] p;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.cmd        = omt_pkg::CMD_CREATE;
		req_ch.slot_id    = '0;
		req_ch.caller_pid = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lock on a slot never created, then busy, owner mismatch, release
		send_request(omt_pkg::CMD_LOCK, 8'd3, 16'hFFFF);
		send_request(omt_pkg::CMD_LOCK, 8'd3, 16'd5);
		send_request(omt_pkg::CMD_UNLOCK, 8'd3, 16'd5);
		send_request(omt_pkg::CMD_FREE, 8'd3, 16'hFFFF);
		// slots outside the table
		send_request(omt_pkg::CMD_LOCK, 8'd255, 16'd1);
		send_request(omt_pkg::CMD_UNLOCK, 8'd16, 16'd1);
		// caller id zero: release of a free slot succeeds, create leaves it free
		send_request(omt_pkg::CMD_FREE, 8'd7, 16'd0);
		send_request(omt_pkg::CMD_CREATE, 8'd0, 16'd0);
		// fill the whole table, then one create too many
		for (int i = 0; i < NUM_SLOTS; i++)
			send_request(omt_pkg::CMD_CREATE, (i % 2) ? 8'hFF : 8'h00, 16'h8000 | 16'(i));
		send_request(omt_pkg::CMD_CREATE, 8'hAA, 16'h7FFF);

		// random part: mostly owner-aware sequences, some noise
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			c    = omt_pkg::CMD_CREATE;
			s    = $urandom_range(0, NUM_SLOTS - 1);
			p    = 16'($urandom_range(1, 65535));
			if (pick < 15) begin
				s = $urandom_range(0, 255);
			end else if (pick < 35) begin
				c = omt_pkg::CMD_LOCK;
			end else if (pick < 62) begin
				// release by the true owner
				s = find_slot(1'b0);
				if (s >= 0) begin
					c = $urandom_range(0, 1) ? omt_pkg::CMD_UNLOCK : omt_pkg::CMD_FREE;
					p = stim_view.owner[s];
				end else begin
					s = 0;
				end
			end else if (pick < 72) begin
				// retry on a held lock
				c = omt_pkg::CMD_LOCK;
				s = find_slot(1'b1);
				if (s < 0)
					s = $urandom_range(0, NUM_SLOTS - 1);
			end else if (pick < 82) begin
				// release by someone else
				c = $urandom_range(0, 1) ? omt_pkg::CMD_UNLOCK : omt_pkg::CMD_FREE;
				s = find_slot(1'b0);
				if (s < 0)
					s = $urandom_range(0, NUM_SLOTS - 1);
				p = stim_view.owner[s] ^ 16'($urandom_range(1, 65535));
			end else begin
				c = omt_pkg::cmd_e_t'($urandom_range(0, 3));
				s = $urandom_range(0, 255);
			end
			send_request(c, s[omt_pkg::SLOT_W-1:0], p);
		end
		req_ch.valid <= 1'b0;

		// drain
		@(posedge clk);
		while (mirror.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mirror.pending_rsp.size() != 0) begin
			mirror.mismatches++;
			$display("%0t: %0d responses never arrived", $time, mirror.pending_rsp.size());
		end

		$display("covered %0d requests, %0d responses: ok %0d, error %0d, busy %0d",
			mirror.n_req, mirror.n_rsp, mirror.n_ok, mirror.n_err, mirror.n_busy);
		$display("releases with wake %0d, creates on a full table %0d",
			mirror.n_wake, mirror.n_full);
		if (mirror.mismatches == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

FILE: files.f
src/omt_pkg.sv
src/omt_req_if.sv
src/omt_rsp_if.sv
src/omt_ctrl.sv
src/omt_datapath.sv
src/owned_mutex_table.sv
dv/testbench.sv
